/* rtl/bdq_pkg.sv */
// Shared types, constants and table functions for the 16x16 DCT quantizer.
package bdq_pkg;

	localparam int BLOCK_SIZE = 16;
	localparam int NPIX       = BLOCK_SIZE * BLOCK_SIZE;
	localparam int ROW_FRAC   = 10;
	localparam int ROW_W      = 24;
	localparam int GRAY_W     = 8;
	localparam int QUAL_W     = 16;
	localparam int NUM_W      = 25;

	// floor(x / 1000) == (x * GRAY_RECIP) >> GRAY_RECIP_SH for x < 2^17
	localparam logic [17:0] GRAY_RECIP    = 18'd134218;
	localparam int          GRAY_RECIP_SH = 27;
	localparam logic [17:0] GRAY_OFFSET   = 18'd128000;

	// axis scale product times 16, Q14
	localparam logic [15:0] SCALE_DC   = 16'd16384;
	localparam logic [15:0] SCALE_EDGE = 16'd23170;
	localparam logic [15:0] SCALE_AC   = 16'd32768;

	localparam logic [6:0] TH_DC    = 7'd16;
	localparam logic [6:0] TH_OUTER = 7'd120;

	localparam logic [63:0] COS_E10 [17] = '{
		64'd10000000000, 64'd9951847267, 64'd9807852804, 64'd9569403357,
		64'd9238795325, 64'd8819212643, 64'd8314696123, 64'd7730104534,
		64'd7071067812, 64'd6343932842, 64'd5555702330, 64'd4713967368,
		64'd3826834324, 64'd2902846773, 64'd1950903220, 64'd980171403,
		64'd0
	};

	localparam logic [4:0] CHROMA8 [64] = '{
		5'd4,  5'd4,  5'd6,  5'd11, 5'd24, 5'd24, 5'd24, 5'd24,
		5'd4,  5'd5,  5'd6,  5'd16, 5'd24, 5'd24, 5'd24, 5'd24,
		5'd6,  5'd6,  5'd14, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24,
		5'd11, 5'd16, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24,
		5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24,
		5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24,
		5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24,
		5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GRAY,
		ST_ROW_RUN,
		ST_ROW_WR,
		ST_COL_RUN,
		ST_Q_ABS,
		ST_Q_MLO,
		ST_Q_MHI,
		ST_Q_NUM,
		ST_Q_DIV,
		ST_Q_SAT,
		ST_OUT
	} state_t;

	// elaboration only: rounded cosine magnitude, cos(m*pi/32) in Q(frac)
	function automatic logic [63:0] cos_q_mag(int m, int frac);
		return ((COS_E10[m] << frac) + 64'd5000000000) / 64'd10000000000;
	endfunction

	// expanded chroma table, in halves
	function automatic logic [6:0] table_half(logic [3:0] u, logic [3:0] v);
		logic [6:0] t;
		if (u == 4'd0 && v == 4'd0) begin
			t = TH_DC;
		end else if (!u[3] && !v[3]) begin
			t = {2'b00, CHROMA8[{u[2:0], v[2:0]}]} * 7'd5;
		end else begin
			t = TH_OUTER;
		end
		return t;
	endfunction

endpackage

/* rtl/bdq_if.sv */
// Channel interfaces: pixel input, quality write, coefficient output.
interface bdq_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

interface bdq_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

interface bdq_coef_if #(parameter int COEF_WIDTH = 16);
	logic                         valid;
	logic                         ready;
	logic signed [COEF_WIDTH-1:0] coef_a;
	logic signed [COEF_WIDTH-1:0] coef_b;
	logic signed [COEF_WIDTH-1:0] coef_c;
	logic signed [COEF_WIDTH-1:0] coef_d;
	logic                         last;
	modport source (output valid, coef_a, coef_b, coef_c, coef_d, last, input ready);
	modport sink (input valid, coef_a, coef_b, coef_c, coef_d, last, output ready);
endinterface

/* rtl/block_dct_quantizer_16x16_top.sv */
// 16x16 block DCT quantizer: gray load, separable DCT on one shared MAC, serial quantizer.
//
//  channel | dir | payload                          | transaction
//  pix     | in  | red, green, blue                 | one pixel, row-major
//  cfg     | in  | data = quality_q8                | one quality write
//  coef    | out | coef_a..coef_d, last             | four coefficients, u-major
//
//  Each pixel passes through IDLE and GRAY (gray conversion through one reciprocal
//  multiply). After the 256th pixel the block is busy with 256 row sums and 256
//  column sums on the single MAC (16 terms plus pipeline fill), each column sum
//  followed by the quantizer with its serial divider, and one output per group.
//  arst_n clears control state; the stores are not cleared.
//  A held output group stalls the sequencer until coef.ready.
module block_dct_quantizer_16x16_top
	import bdq_pkg::*;
#(
	parameter int COS_FRAC_BITS = 14,
	parameter int COEF_WIDTH    = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	bdq_pix_if.sink       pix,
	bdq_cfg_if.sink       cfg,
	bdq_coef_if.source    coef
);

	localparam int CMW   = COS_FRAC_BITS + 1;
	localparam int CSW   = COS_FRAC_BITS + 2;
	localparam int PW    = ROW_W + CSW;
	localparam int DW    = COS_FRAC_BITS + 30;
	localparam int HW    = DW - 24;
	localparam int MW    = DW + 16;
	localparam int RSH   = COS_FRAC_BITS - ROW_FRAC;
	localparam int QSH   = COS_FRAC_BITS + 18;
	localparam logic [DW-1:0] RHALF = (RSH == 0) ? '0 : (DW'(1) << (RSH - 1));
	localparam logic [NUM_W-1:0] LIM_POS = (NUM_W'(1) << (COEF_WIDTH - 1)) - NUM_W'(1);
	localparam logic [NUM_W-1:0] LIM_NEG = NUM_W'(1) << (COEF_WIDTH - 1);

	localparam logic [CMW-1:0] COS_TAB [17] = '{
		CMW'(cos_q_mag(0, COS_FRAC_BITS)),  CMW'(cos_q_mag(1, COS_FRAC_BITS)),
		CMW'(cos_q_mag(2, COS_FRAC_BITS)),  CMW'(cos_q_mag(3, COS_FRAC_BITS)),
		CMW'(cos_q_mag(4, COS_FRAC_BITS)),  CMW'(cos_q_mag(5, COS_FRAC_BITS)),
		CMW'(cos_q_mag(6, COS_FRAC_BITS)),  CMW'(cos_q_mag(7, COS_FRAC_BITS)),
		CMW'(cos_q_mag(8, COS_FRAC_BITS)),  CMW'(cos_q_mag(9, COS_FRAC_BITS)),
		CMW'(cos_q_mag(10, COS_FRAC_BITS)), CMW'(cos_q_mag(11, COS_FRAC_BITS)),
		CMW'(cos_q_mag(12, COS_FRAC_BITS)), CMW'(cos_q_mag(13, COS_FRAC_BITS)),
		CMW'(cos_q_mag(14, COS_FRAC_BITS)), CMW'(cos_q_mag(15, COS_FRAC_BITS)),
		CMW'(cos_q_mag(16, COS_FRAC_BITS))
	};

	state_t state_q, state_d;

	logic [QUAL_W-1:0] quality_q;
	logic [7:0]        load_q;
	logic [7:0]        idx_q;
	logic [4:0]        issue_q;

	logic              pix_ready, issue, col_phase, out_valid, run;
	logic              pix_fire, cfg_fire, coef_fire;

	// gray conversion
	logic [17:0]       gpos, gabs;
	logic              gneg;
	logic              gneg_q;
	logic [16:0]       gmag_q;
	logic [34:0]       gprod;
	logic [7:0]        gq, gval;

	// stores
	logic [GRAY_W-1:0] gray_mem [NPIX];
	logic [ROW_W-1:0]  row_mem [NPIX];
	logic [GRAY_W-1:0] gray_rd_q;
	logic [ROW_W-1:0]  row_rd_q;

	// cosine lookup
	logic [8:0]        mprod;
	logic [6:0]        mf;
	logic              cneg;
	logic [CMW-1:0]    cmag;
	logic signed [CSW-1:0] cos_val;

	// MAC pipeline
	logic              v_s1, first_s1, last_s1, col_s1;
	logic signed [CSW-1:0] cos_s1;
	logic signed [ROW_W-1:0] op_s1;
	logic              v_s2, first_s2, last_s2;
	logic signed [PW-1:0] prod_s2;
	logic signed [DW-1:0] acc_q;
	logic              done_q;

	// row write rounding
	logic [DW-1:0]     amag, rnd;
	logic [DW-1:0]     rval;

	// quantizer
	logic [DW-1:0]     dmag_q;
	logic              dneg_q;
	logic [22:0]       den_q;
	logic [15:0]       scale_q, scale_d;
	logic [QUAL_W-1:0] qual_eff;
	logic [39:0]       plo_q;
	logic [HW+15:0]    phi_q;
	logic [MW-1:0]     magsum;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W:0]    rem_q, rem_sh, dv;
	logic              qbit;
	logic [4:0]        div_cnt_q;
	logic [NUM_W-1:0]  qlim, qsat;
	logic [COEF_WIDTH-1:0] cval;

	logic [COEF_WIDTH-1:0] coef_q [4];
	logic              last_q;

	assign pix_fire  = pix.valid && pix.ready;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign coef_fire = coef.valid && coef.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (pix_fire) state_d = ST_GRAY;
			ST_GRAY:    state_d = (load_q == 8'd255) ? ST_ROW_RUN : ST_IDLE;
			ST_ROW_RUN: if (done_q) state_d = ST_ROW_WR;
			ST_ROW_WR:  state_d = (idx_q == 8'd255) ? ST_COL_RUN : ST_ROW_RUN;
			ST_COL_RUN: if (done_q) state_d = ST_Q_ABS;
			ST_Q_ABS:   state_d = ST_Q_MLO;
			ST_Q_MLO:   state_d = ST_Q_MHI;
			ST_Q_MHI:   state_d = ST_Q_NUM;
			ST_Q_NUM:   state_d = ST_Q_DIV;
			ST_Q_DIV:   if (div_cnt_q == 5'(NUM_W - 1)) state_d = ST_Q_SAT;
			ST_Q_SAT:   state_d = (idx_q[1:0] == 2'd3) ? ST_OUT : ST_COL_RUN;
			ST_OUT: begin
				if (coef_fire) state_d = (idx_q == 8'd0) ? ST_IDLE : ST_COL_RUN;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		pix_ready = (state_q == ST_IDLE);
		col_phase = (state_q == ST_COL_RUN);
		run       = (state_q == ST_ROW_RUN) || (state_q == ST_COL_RUN);
		issue     = run && !issue_q[4];
		out_valid = (state_q == ST_OUT);
	end

	assign pix.ready   = pix_ready;
	assign cfg.ready   = 1'b1;
	assign coef.valid  = out_valid;
	assign coef.coef_a = coef_q[0];
	assign coef.coef_b = coef_q[1];
	assign coef.coef_c = coef_q[2];
	assign coef.coef_d = coef_q[3];
	assign coef.last   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			quality_q <= 16'd128;
			load_q    <= '0;
			idx_q     <= '0;
			issue_q   <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			done_q    <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_fire) quality_q <= cfg.data;
			if (state_q == ST_GRAY) load_q <= load_q + 8'd1;
			if (state_q == ST_ROW_WR || state_q == ST_Q_SAT) idx_q <= idx_q + 8'd1;
			if (run) begin
				if (!issue_q[4]) issue_q <= issue_q + 5'd1;
			end else begin
				issue_q <= '0;
			end
			v_s1   <= issue;
			v_s2   <= v_s1;
			done_q <= v_s2 && last_s2;
			if (state_q == ST_Q_NUM) div_cnt_q <= '0;
			else if (state_q == ST_Q_DIV) div_cnt_q <= div_cnt_q + 5'd1;
		end
	end

	// gray = (299R + 587G + 114B - 128000) / 1000, half away from zero
	always_comb begin
		gpos = 18'd299 * pix.red + 18'd587 * pix.green + 18'd114 * pix.blue;
		gneg = gpos < GRAY_OFFSET;
		gabs = gneg ? (GRAY_OFFSET - gpos) : (gpos - GRAY_OFFSET);
		gprod = {18'b0, gmag_q} * {17'b0, GRAY_RECIP};
		gq    = gprod[GRAY_RECIP_SH +: 8];
		gval  = gneg_q ? (8'd0 - gq) : gq;
	end

	always_ff @(posedge clk) begin
		if (pix_fire) begin
			gneg_q <= gneg;
			gmag_q <= 17'(gabs + 18'd500);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_GRAY) gray_mem[load_q] <= gval;
		gray_rd_q <= gray_mem[{idx_q[7:4], issue_q[3:0]}];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ROW_WR) row_mem[idx_q] <= rval[ROW_W-1:0];
		row_rd_q <= row_mem[{issue_q[3:0], idx_q[7:4]}];
	end

	// cos(pi*(2x+1)*k/32), folded onto the first quadrant
	always_comb begin
		mprod = {3'b0, issue_q[3:0], 1'b1} * {5'b0, idx_q[3:0]};
		mf    = {1'b0, mprod[5:0]};
		cneg  = 1'b0;
		if (mf > 7'd32) mf = 7'd64 - mf;
		if (mf > 7'd16) begin
			mf   = 7'd32 - mf;
			cneg = 1'b1;
		end
		cmag    = COS_TAB[mf[4:0]];
		cos_val = cneg ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
	end

	assign op_s1 = col_s1 ? $signed(row_rd_q) : ROW_W'($signed(gray_rd_q));

	always_ff @(posedge clk) begin
		first_s1 <= (issue_q[3:0] == 4'd0);
		last_s1  <= (issue_q[3:0] == 4'd15);
		col_s1   <= col_phase;
		cos_s1   <= cos_val;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		prod_s2  <= op_s1 * cos_s1;
		if (v_s2) begin
			if (first_s2) acc_q <= DW'(prod_s2);
			else acc_q <= acc_q + DW'(prod_s2);
		end
	end

	// row pass: round to ROW_FRAC fraction bits, half away from zero
	always_comb begin
		amag = acc_q[DW-1] ? (DW'(0) - DW'(acc_q)) : DW'(acc_q);
		rnd  = (amag + RHALF) >> RSH;
		rval = acc_q[DW-1] ? (DW'(0) - rnd) : rnd;
	end

	always_comb begin
		qual_eff = (quality_q == '0) ? QUAL_W'(1) : quality_q;
		if (idx_q == 8'd0) scale_d = SCALE_DC;
		else if (idx_q[7:4] == 4'd0 || idx_q[3:0] == 4'd0) scale_d = SCALE_EDGE;
		else scale_d = SCALE_AC;
		magsum = {phi_q, 24'b0} + MW'(plo_q);
		dv     = {2'b0, den_q, 1'b0};
		rem_sh = {rem_q[NUM_W-1:0], num_q[NUM_W-1]};
		qbit   = rem_sh >= dv;
		qlim   = dneg_q ? LIM_NEG : LIM_POS;
		qsat   = (num_q > qlim) ? qlim : num_q;
		cval   = dneg_q ? (COEF_WIDTH'(0) - qsat[COEF_WIDTH-1:0]) : qsat[COEF_WIDTH-1:0];
	end

	// quantizer: q = (|d|*s / 2^(F+18) + den) / (2*den), den = quality * table
	always_ff @(posedge clk) begin
		case (state_q)
			ST_Q_ABS: begin
				dmag_q  <= amag;
				dneg_q  <= acc_q[DW-1];
				scale_q <= scale_d;
				den_q   <= {7'b0, qual_eff} * {16'b0, table_half(idx_q[7:4], idx_q[3:0])};
			end
			ST_Q_MLO: plo_q <= {16'b0, dmag_q[23:0]} * {24'b0, scale_q};
			ST_Q_MHI: phi_q <= {16'b0, dmag_q[DW-1:24]} * {HW'(0), scale_q};
			ST_Q_NUM: begin
				num_q <= NUM_W'(magsum >> QSH) + NUM_W'(den_q);
				rem_q <= '0;
			end
			ST_Q_DIV: begin
				rem_q <= qbit ? (rem_sh - dv) : rem_sh;
				num_q <= {num_q[NUM_W-2:0], qbit};
			end
			ST_Q_SAT: begin
				coef_q[idx_q[1:0]] <= cval;
				last_q <= (idx_q == 8'd255);
			end
			default: ;
		endcase
	end

endmodule

/* dv/testbench.sv */
// Testbench for the 16x16 DCT quantizer: block-level predictor, random flow control.
`timescale 1ns / 100ps

module testbench;
	import bdq_pkg::*;

	localparam int CW        = 16;
	localparam int COS_FRAC  = 14;
	localparam int IDLE_WAIT = 60;
	localparam int WD_LIMIT  = 100000;

	typedef struct packed {
		logic signed [CW-1:0] a;
		logic signed [CW-1:0] b;
		logic signed [CW-1:0] c;
		logic signed [CW-1:0] d;
		logic                 last;
	} coef_group_t;

	logic clk;
	logic arst_n;

	bdq_pix_if            pix_if();
	bdq_cfg_if            cfg_if();
	bdq_coef_if #(.COEF_WIDTH(CW)) coef_if();

	block_dct_quantizer_16x16_top #(.COS_FRAC_BITS(COS_FRAC), .COEF_WIDTH(CW)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix_if),
		.cfg(cfg_if),
		.coef(coef_if)
	);

	// predictor state
	logic [15:0]       quality;
	logic signed [7:0] gray_mem [NPIX];
	logic [7:0]        pix_count;
	coef_group_t       expected_groups[$];

	int  errors;
	int  idle_cycles;
	int  hold_off;
	bit  gaps_on;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [7:0] to_gray(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		longint t;
		t = 299 * longint'(r) + 587 * longint'(g) + 114 * longint'(b) - 128000;
		if (t < 0) return 8'(-((-t + 500) / 1000));
		return 8'((t + 500) / 1000);
	endfunction

	function automatic longint cos_fix(int k, int x);
		int m;
		bit neg;
		longint unsigned mag;
		m = ((2 * x + 1) * k) & 63;
		neg = 0;
		if (m > 32) m = 64 - m;
		if (m > 16) begin
			m = 32 - m;
			neg = 1;
		end
		mag = ((COS_E10[m] << COS_FRAC) + 64'd5000000000) / 64'd10000000000;
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint round_half_away(longint a, int sh);
		longint unsigned mag;
		mag = a < 0 ? -a : a;
		if (sh > 0) mag = (mag + (64'd1 << (sh - 1))) >> sh;
		return a < 0 ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic logic signed [CW-1:0] quantize_coef(longint d, int u, int v);
		longint unsigned s, th, mag, den, q, lim, qual;
		if (u == 0 && v == 0) s = 16384;
		else if (u == 0 || v == 0) s = 23170;
		else s = 32768;
		if (u == 0 && v == 0) th = 16;
		else if (u < 8 && v < 8) th = 5 * CHROMA8[u * 8 + v];
		else th = 120;
		qual = quality == 0 ? 1 : quality;
		mag = (d < 0 ? -d : d) * s;
		den = (qual * th) << (ROW_FRAC + COS_FRAC + 9);
		q = (mag + den / 2) / den;
		lim = d < 0 ? (64'd1 << (CW - 1)) : (64'd1 << (CW - 1)) - 1;
		if (q > lim) q = lim;
		return CW'(d < 0 ? -longint'(q) : longint'(q));
	endfunction

	// full block: row pass, column pass, quantize, pack into groups of four
	task automatic predict_block();
		longint row_sum [NPIX];
		longint acc;
		logic signed [CW-1:0] c [NPIX];
		coef_group_t grp;
		for (int y = 0; y < BLOCK_SIZE; y++)
			for (int u = 0; u < BLOCK_SIZE; u++) begin
				acc = 0;
				for (int x = 0; x < BLOCK_SIZE; x++)
					acc += longint'(gray_mem[y * BLOCK_SIZE + x]) * cos_fix(u, x);
				row_sum[y * BLOCK_SIZE + u] = round_half_away(acc, COS_FRAC - ROW_FRAC);
			end
		for (int k = 0; k < NPIX; k++) begin
			acc = 0;
			for (int y = 0; y < BLOCK_SIZE; y++)
				acc += row_sum[y * BLOCK_SIZE + k / BLOCK_SIZE] * cos_fix(k % BLOCK_SIZE, y);
			c[k] = quantize_coef(acc, k / BLOCK_SIZE, k % BLOCK_SIZE);
		end
		for (int k = 0; k < NPIX / 4; k++) begin
			grp.a = c[4 * k];
			grp.b = c[4 * k + 1];
			grp.c = c[4 * k + 2];
			grp.d = c[4 * k + 3];
			grp.last = (k == NPIX / 4 - 1);
			expected_groups.push_back(grp);
		end
	endtask

	// valid stays high between back-to-back pixels
	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			pix_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.red   <= r;
		pix_if.green <= g;
		pix_if.blue  <= b;
		do @(posedge clk); while (!pix_if.ready);
		gray_mem[pix_count] = to_gray(r, g, b);
		pix_count++;
		if (pix_count == 0) predict_block();
	endtask

	task automatic wait_drained();
		@(posedge clk);
		pix_if.valid <= 1'b0;
		while (expected_groups.size() != 0) @(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic write_quality(logic [15:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= value;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		quality = value;
	endtask

	task automatic send_random_pixels(int n, bit extremes);
		logic [7:0] r, g, b;
		for (int i = 0; i < n; i++) begin
			r = extremes ? {8{$urandom_range(0, 1) == 1}} : $urandom_range(0, 255);
			g = extremes ? {8{$urandom_range(0, 1) == 1}} : $urandom_range(0, 255);
			b = extremes ? {8{$urandom_range(0, 1) == 1}} : $urandom_range(0, 255);
			send_pixel(r, g, b);
		end
	endtask

	// reset quality, field extremes and mid-gray pixels first
	task automatic test_reset_quality();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd127, 8'd127, 8'd127);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd170, 8'd85, 8'd170);
		send_pixel(8'd85, 8'd170, 8'd85);
		send_random_pixels(NPIX - 11, 1'b0);
		wait_drained();
	endtask

	// zero quality acts as one; full-swing pixels drive the coefficients into saturation
	task automatic test_quality_zero();
		write_quality(16'hFFFF);
		@(posedge clk);
		write_quality(16'd0);
		gaps_on = 0;
		send_random_pixels(NPIX - 8, 1'b1);
		gaps_on = 1;
	endtask

	// receiver holds off while the block finishes and further pixels are offered
	task automatic test_output_stall();
		hold_off = 25000;
		send_random_pixels(8, 1'b1);
		send_random_pixels(8, 1'b0);
		wait_drained();
	endtask

	// coefficient receiver
	initial begin
		coef_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off > 0) begin
				coef_if.ready <= 1'b0;
				repeat (hold_off) @(posedge clk);
				hold_off = 0;
			end else if (gap_len() > 0) begin
				coef_if.ready <= 1'b0;
				repeat (gap_len() + 1) @(posedge clk);
			end else begin
				coef_if.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		coef_group_t exp_grp;
		if (coef_if.valid && coef_if.ready) begin
			if (expected_groups.size() == 0) begin
				$display("%0t: unexpected transaction a=%0d b=%0d c=%0d d=%0d last=%0b",
					$time, coef_if.coef_a, coef_if.coef_b, coef_if.coef_c,
					coef_if.coef_d, coef_if.last);
				errors++;
			end else begin
				exp_grp = expected_groups.pop_front();
				if (coef_if.coef_a !== exp_grp.a || coef_if.coef_b !== exp_grp.b ||
						coef_if.coef_c !== exp_grp.c || coef_if.coef_d !== exp_grp.d ||
						coef_if.last !== exp_grp.last) begin
					$display("%0t: mismatch exp a=%0d b=%0d c=%0d d=%0d last=%0b", $time,
						exp_grp.a, exp_grp.b, exp_grp.c, exp_grp.d, exp_grp.last);
					$display("%0t:          act a=%0d b=%0d c=%0d d=%0d last=%0b", $time,
						coef_if.coef_a, coef_if.coef_b, coef_if.coef_c, coef_if.coef_d,
						coef_if.last);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((pix_if.valid && pix_if.ready) || (cfg_if.valid && cfg_if.ready) ||
				(coef_if.valid && coef_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WD_LIMIT) begin
			$display("%0t: timeout, %0d groups outstanding", $time, expected_groups.size());
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		pix_if.valid = 1'b0;
		pix_if.red = '0;
		pix_if.green = '0;
		pix_if.blue = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		quality = 16'd128;
		pix_count = '0;
		errors = 0;
		idle_cycles = 0;
		hold_off = 0;
		gaps_on = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_quality();
		test_quality_zero();
		test_output_stall();
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_groups.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
